>>> sv/tot_pkg.sv
// tot_pkg: shared types, codes and default sizes for the tile overlap table
// used by the channel interfaces, the table itself and its checker
package tot_pkg;

  // fixed widths of the request and result fields
  localparam int COORD_W     = 16;
  localparam int NUM_IN_DIMS = 4;
  localparam int COUNT_OUT_W = 7;
  localparam int NUMDIMS_W   = 3;

  // default table sizes
  localparam int MAX_BOXES_DEF  = 64;
  localparam int MAX_DIMS_DEF   = 4;
  localparam int COORD_BITS_DEF = 16;

  // configuration
  localparam int                 CFG_ADDR_W     = 3;
  localparam int                 CFG_DATA_W     = 32;
  localparam logic               REG_NUM_DIMS   = 1'b0;
  localparam logic [NUMDIMS_W-1:0] NUM_DIMS_RESET = 3'd4;

  // request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // result status
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } tot_state_t;

endpackage

>>> sv/tot_req_if.sv
// tot_req_if: request channel of the tile overlap table (insert or query a box)
// depends on tot_pkg for the field widths
interface tot_req_if import tot_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] lo_0;
  logic [COORD_W-1:0] hi_0;
  logic [COORD_W-1:0] lo_1;
  logic [COORD_W-1:0] hi_1;
  logic [COORD_W-1:0] lo_2;
  logic [COORD_W-1:0] hi_2;
  logic [COORD_W-1:0] lo_3;
  logic [COORD_W-1:0] hi_3;

  modport source (
    output valid, kind, lo_0, hi_0, lo_1, hi_1, lo_2, hi_2, lo_3, hi_3,
    input  ready
  );
  modport sink (
    input  valid, kind, lo_0, hi_0, lo_1, hi_1, lo_2, hi_2, lo_3, hi_3,
    output ready
  );
endinterface

// tot_rsp_if: result channel of the tile overlap table
// depends on tot_pkg for the field widths
interface tot_rsp_if import tot_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   overlap;
  logic                   status;
  logic [COUNT_OUT_W-1:0] box_count;

  modport source (
    output valid, overlap, status, box_count,
    input  ready
  );
  modport sink (
    input  valid, overlap, status, box_count,
    output ready
  );
endinterface

>>> sv/tile_overlap_table.sv
// tile_overlap_table: table of half-open integer boxes with insert and overlap query
// depends on tot_pkg and the tot_req_if / tot_rsp_if channel interfaces
//
// Usage:
//   in_ch carries requests: kind selects insert (append box) or query (does the
//   box overlap any stored box). out_ch returns one result per request: overlap,
//   status (insert dropped because the table is full) and the stored box count.
//   cfg_* is an APB-style port; num_dims lives at byte address 0.
// Flow:
//   insert: the request goes to the finish state, which loads the output register
//   once it is free. query: the scan state tests stored boxes in order and stops at
//   the first overlapping box, then the finish state loads the result. The table has
//   one read port and a single compare unit, so one stored box is tested per cycle.
//   One request is in work at a time; in_ch.ready is high only when idle, so a new
//   request is taken only once the previous one has left the finish state.
//   A new request may be taken while the previous result still waits in the
//   output register.
// Reset: rst_n (synchronous, active low) empties the table and sets num_dims
//   to 4. No clearing pass is needed; only entries below the count are read.
// Stall: a result held by out_ch.ready keeps its value; a finished request
//   waits inside until the output register is free.
module tile_overlap_table import tot_pkg::*; #(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tot_req_if.sink               in_ch,
  tot_rsp_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int STORE_DIMS = (MAX_DIMS < NUM_IN_DIMS) ? MAX_DIMS : NUM_IN_DIMS;
  localparam int CW         = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int ENTRY_W    = 2 * STORE_DIMS * CW;
  localparam int AW         = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNTW       = $clog2(MAX_BOXES + 1);

  typedef logic [STORE_DIMS-1:0][CW-1:0] box_side_t;

  tot_state_t state_r, state_nxt;

  logic [NUMDIMS_W-1:0]   num_dims_r;
  logic [CNTW-1:0]        cnt_r;
  logic [CNTW-1:0]        idx_r;
  logic                   rd_vld_r;
  logic [ENTRY_W-1:0]     rd_data_r;
  box_side_t              q_lo_r, q_hi_r;
  logic                   res_overlap_r, res_status_r;
  logic                   out_valid_r, out_overlap_r, out_status_r;
  logic [COUNT_OUT_W-1:0] out_count_r;

  logic [ENTRY_W-1:0] mem [MAX_BOXES];

  logic [NUM_IN_DIMS-1:0][COORD_W-1:0] all_lo, all_hi;
  box_side_t          in_lo, in_hi, ent_lo, ent_hi;
  logic [STORE_DIMS-1:0] dim_ok;
  logic               match;
  logic               accept, is_insert, table_full, cfg_wr;
  logic               in_ready, issue, load_out, out_free;

  // request boxes, cut to the stored coordinate width
  assign all_lo = {in_ch.lo_3, in_ch.lo_2, in_ch.lo_1, in_ch.lo_0};
  assign all_hi = {in_ch.hi_3, in_ch.hi_2, in_ch.hi_1, in_ch.hi_0};

  always_comb begin
    for (int d = 0; d < STORE_DIMS; d++) begin
      in_lo[d] = all_lo[d][CW-1:0];
      in_hi[d] = all_hi[d][CW-1:0];
    end
  end

  assign accept     = in_ch.valid && in_ready;
  assign is_insert  = (in_ch.kind == KIND_INSERT);
  assign table_full = (cnt_r == CNTW'(MAX_BOXES));
  assign out_free   = !out_valid_r || out_ch.ready;

  // shared compare unit: query box against the entry read last cycle
  assign {ent_hi, ent_lo} = rd_data_r;

  always_comb begin
    for (int d = 0; d < STORE_DIMS; d++) begin
      dim_ok[d] = (NUMDIMS_W'(d) >= num_dims_r) ||
                  ((q_lo_r[d] < ent_hi[d]) && (ent_lo[d] < q_hi_r[d]));
    end
  end

  assign match = rd_vld_r && (&dim_ok);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = is_insert ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || (idx_r == cnt_r && !rd_vld_r)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   issue    = !match && (idx_r != cnt_r);
      ST_FINISH: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_dims_r  <= NUM_DIMS_RESET;
      cnt_r       <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (cfg_wr) begin
        num_dims_r <= cfg_pwdata[NUMDIMS_W-1:0];
      end
      if (accept && is_insert && !table_full) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (accept) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      q_lo_r        <= in_lo;
      q_hi_r        <= in_hi;
      res_overlap_r <= 1'b0;
      res_status_r  <= (is_insert && table_full) ? STATUS_FULL : STATUS_OK;
    end else if (match) begin
      res_overlap_r <= 1'b1;
    end
    if (load_out) begin
      out_overlap_r <= res_overlap_r;
      out_status_r  <= res_status_r;
      out_count_r   <= COUNT_OUT_W'(cnt_r);
    end
  end

  // box table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (accept && is_insert && !table_full) begin
      mem[cnt_r[AW-1:0]] <= {in_hi, in_lo};
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  // configuration port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_NUM_DIMS);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_NUM_DIMS) ?
                      CFG_DATA_W'(num_dims_r) : '0;

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.overlap   = out_overlap_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.box_count = out_count_r;

endmodule

>>> sv/tot_checker.sv
// tot_checker: port-level assertions for the tile overlap table
// depends on tot_pkg; attached to tile_overlap_table by the bind below
module tot_checker import tot_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_overlap,
  input logic                   out_status,
  input logic [COUNT_OUT_W-1:0] out_count
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_overlap) &&
      $stable(out_status) && $stable(out_count))
    else $error("result changed while stalled");

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // a dropped insert only happens with a full table
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> out_count == COUNT_OUT_W'(MAX_BOXES))
    else $error("insert dropped without a full table");

  // a dropped insert never reports an overlap
  a_drop_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FULL |-> !out_overlap)
    else $error("dropped insert reports an overlap");

endmodule

bind tile_overlap_table tot_checker #(.MAX_BOXES(MAX_BOXES)) u_tot_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_overlap(out_ch.overlap),
  .out_status (out_ch.status),
  .out_count  (out_ch.box_count)
);
